// ===== hdl/nkwm_pkg.sv =====
// Shared types, default sizes and the character decoder for the k-mer window matcher.
// No dependencies; every other file of the block imports this package.
package nkwm_pkg;

  localparam int SAMPLE_TOKENS_DEF  = 15;
  localparam int PATTERN_TOKENS_DEF = 12;
  localparam int PATTERN_DEPTH_DEF  = 64;
  localparam int NUMBER_W           = 16;
  localparam int QUEUE_DEPTH        = 4;

  localparam logic [7:0] SYM_G = 8'h47;
  localparam logic [7:0] SYM_A = 8'h41;
  localparam logic [7:0] SYM_T = 8'h54;
  localparam logic [7:0] SYM_C = 8'h43;

  localparam logic [1:0] TOK_G = 2'd0;
  localparam logic [1:0] TOK_A = 2'd1;
  localparam logic [1:0] TOK_T = 2'd2;
  localparam logic [1:0] TOK_C = 2'd3;

  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_SAMPLE  = 1'b1;

  // One classified token as it travels from the front to the back.
  typedef struct packed {
    logic       is_sample;
    logic [1:0] code;
  } tok_t;

  typedef struct packed {
    logic       known;
    logic [1:0] code;
  } decode_t;

  function automatic decode_t token_decode(input logic [7:0] sym);
    decode_t d;
    d.known = 1'b1;
    d.code  = TOK_G;
    case (sym)
      SYM_G:   d.code = TOK_G;
      SYM_A:   d.code = TOK_A;
      SYM_T:   d.code = TOK_T;
      SYM_C:   d.code = TOK_C;
      default: d.known = 1'b0;
    endcase
    return d;
  endfunction

endpackage

// ===== hdl/nkwm_front.sv =====
// Front end: takes input beats, decodes the byte and drops anything but G, A, T, C.
// Depends on nkwm_pkg; feeds nkwm_queue.
module nkwm_front (
  input  logic          item_valid,
  output logic          item_stall,
  input  logic          operation,
  input  logic [7:0]    symbol,
  input  logic          q_full,
  output logic          q_push,
  output nkwm_pkg::tok_t q_wdata
);
  import nkwm_pkg::*;

  decode_t dec;

  assign dec        = token_decode(symbol);
  // Ignored bytes are still taken, so only a full queue holds the input back.
  assign item_stall = q_full;
  assign q_push     = item_valid && !q_full && dec.known;
  assign q_wdata.is_sample = (operation == OP_SAMPLE);
  assign q_wdata.code      = dec.code;

endmodule

// ===== hdl/nkwm_queue.sv =====
// Short token queue that decouples the front end from the matching engine.
// Depends on nkwm_pkg for the token type and depth.
module nkwm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  nkwm_pkg::tok_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           rvalid,
  output nkwm_pkg::tok_t rdata
);
  import nkwm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tok_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full   = (fill == CNT_W'(QUEUE_DEPTH));
  assign rvalid = (fill != '0);
  assign rdata  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== hdl/nkwm_back.sv =====
// Matching engine: builds pattern and sample words, keeps the pattern table and
// scans it once per completed sample. Depends on nkwm_pkg; fed by nkwm_queue.
module nkwm_back #(
  parameter int SAMPLE_TOKENS  = nkwm_pkg::SAMPLE_TOKENS_DEF,
  parameter int PATTERN_TOKENS = nkwm_pkg::PATTERN_TOKENS_DEF,
  parameter int PATTERN_DEPTH  = nkwm_pkg::PATTERN_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  nkwm_pkg::tok_t                 q_rdata,
  output logic                           q_pop,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [2*SAMPLE_TOKENS-1:0]     sample_word,
  output logic [nkwm_pkg::NUMBER_W-1:0]  sample_number
);
  import nkwm_pkg::*;

  localparam int SW    = 2 * SAMPLE_TOKENS;
  localparam int PW    = 2 * PATTERN_TOKENS;
  localparam int STC_W = $clog2(SAMPLE_TOKENS + 1);
  localparam int PTC_W = $clog2(PATTERN_TOKENS + 1);
  localparam int CNT_W = $clog2(PATTERN_DEPTH + 1);
  localparam int AW    = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam bit HAS_WIN = (PATTERN_TOKENS <= SAMPLE_TOKENS);
  localparam int WIN   = HAS_WIN ? (SAMPLE_TOKENS - PATTERN_TOKENS + 1) : 1;

  typedef enum logic [1:0] {
    ST_TAKE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t                state;
  logic [PW-1:0]         pattern_shift;
  logic [PTC_W-1:0]      pattern_tc;
  logic [SW-1:0]         sample_shift;
  logic [STC_W-1:0]      sample_tc;
  logic [CNT_W-1:0]      pattern_count;
  logic [NUMBER_W-1:0]   sample_counter;
  logic [NUMBER_W-1:0]   cur_number;
  logic [CNT_W-1:0]      scan_idx;
  logic                  live;
  logic                  hit;

  logic [PW-1:0]         pattern_table [PATTERN_DEPTH];
  logic [PW-1:0]         rd_data;

  logic [PW+1:0]         pattern_cat;
  logic [SW+1:0]         sample_cat;
  logic [PW-1:0]         pattern_shift_next;
  logic [SW-1:0]         sample_shift_next;
  logic                  pattern_done;
  logic                  sample_done;
  logic                  table_we;
  logic                  out_free;
  logic                  emit_now;
  logic [WIN-1:0]        win_eq;
  logic                  match_now;

  assign pattern_cat        = {pattern_shift, q_rdata.code};
  assign sample_cat         = {sample_shift, q_rdata.code};
  assign pattern_shift_next = pattern_cat[PW-1:0];
  assign sample_shift_next  = sample_cat[SW-1:0];
  assign pattern_done = (pattern_tc == PTC_W'(PATTERN_TOKENS - 1));
  assign sample_done  = (sample_tc == STC_W'(SAMPLE_TOKENS - 1));

  assign q_pop    = (state == ST_TAKE) && q_valid;
  assign table_we = q_pop && !q_rdata.is_sample && pattern_done &&
                    (pattern_count < CNT_W'(PATTERN_DEPTH));
  assign out_free = !result_valid || !result_stall;
  assign emit_now = (state == ST_EMIT) && !hit && out_free;

  // Every window of the sample is checked against one table entry per cycle.
  generate
    if (HAS_WIN) begin : g_win
      for (genvar w = 0; w < WIN; w++) begin : g_cmp
        assign win_eq[w] = (sample_shift[2*w +: PW] == rd_data);
      end
    end else begin : g_nowin
      assign win_eq = '0;
    end
  endgenerate

  assign match_now = live && (|win_eq);

  always_ff @(posedge clk) begin
    if (table_we) begin
      pattern_table[pattern_count[AW-1:0]] <= pattern_shift_next;
    end
    rd_data <= pattern_table[scan_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_TAKE;
      pattern_shift  <= '0;
      pattern_tc     <= '0;
      sample_shift   <= '0;
      sample_tc      <= '0;
      pattern_count  <= '0;
      sample_counter <= '0;
      scan_idx       <= '0;
      live           <= 1'b0;
      hit            <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (emit_now) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_TAKE: begin
          if (q_valid) begin
            if (!q_rdata.is_sample) begin
              pattern_shift <= pattern_shift_next;
              if (pattern_done) begin
                pattern_tc <= '0;
                if (table_we) begin
                  pattern_count <= pattern_count + 1'b1;
                end
              end else begin
                pattern_tc <= pattern_tc + 1'b1;
              end
            end else begin
              sample_shift <= sample_shift_next;
              if (sample_done) begin
                sample_tc      <= '0;
                cur_number     <= sample_counter;
                sample_counter <= sample_counter + 1'b1;
                scan_idx       <= '0;
                hit            <= 1'b0;
                live           <= 1'b0;
                state          <= ST_SCAN;
              end else begin
                sample_tc <= sample_tc + 1'b1;
              end
            end
          end
        end
        ST_SCAN: begin
          // The read issued last cycle is compared in this one.
          if (match_now) begin
            hit <= 1'b1;
          end
          if (scan_idx < pattern_count) begin
            live     <= 1'b1;
            scan_idx <= scan_idx + 1'b1;
          end else begin
            live  <= 1'b0;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (hit) begin
            state <= ST_TAKE;
          end else if (out_free) begin
            sample_word   <= sample_shift;
            sample_number <= cur_number;
            state         <= ST_TAKE;
          end
        end
        default: state <= ST_TAKE;
      endcase
    end
  end

endmodule

// ===== hdl/nucleotide_kmer_window_matcher_unit.sv =====
// Top level of the k-mer window matcher: front end, token queue and matching engine.
// Depends on nkwm_pkg, nkwm_front, nkwm_queue and nkwm_back.
//
//   channel  handshake                  payload
//   item     item_valid / item_stall    operation, symbol
//   result   result_valid / result_stall sample_word, sample_number
//
// An ignored byte is taken and dropped by the front in its cycle and never reaches the engine.
// Any other character is consumed by the engine in its take state unless it completes a sample.
// A character that completes a sample starts a scan of the pattern table, read one entry
// per cycle, and the engine then waits in its emit state for as long as the result is stalled.
// Reset is synchronous; the table needs no clearing, only the fill count resets.
// A stalled result holds only the engine; the front keeps filling the queue.
module nucleotide_kmer_window_matcher_unit #(
  parameter int SAMPLE_TOKENS  = nkwm_pkg::SAMPLE_TOKENS_DEF,
  parameter int PATTERN_TOKENS = nkwm_pkg::PATTERN_TOKENS_DEF,
  parameter int PATTERN_DEPTH  = nkwm_pkg::PATTERN_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          operation,
  input  logic [7:0]                    symbol,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [2*SAMPLE_TOKENS-1:0]    sample_word,
  output logic [nkwm_pkg::NUMBER_W-1:0] sample_number
);
  import nkwm_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  tok_t q_wdata;
  tok_t q_rdata;

  nkwm_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .operation  (operation),
    .symbol     (symbol),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  nkwm_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  nkwm_back #(
    .SAMPLE_TOKENS  (SAMPLE_TOKENS),
    .PATTERN_TOKENS (PATTERN_TOKENS),
    .PATTERN_DEPTH  (PATTERN_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .sample_word   (sample_word),
    .sample_number (sample_number)
  );

endmodule

// ===== tb/sv/tb_nucleotide_kmer_window_matcher_unit.sv =====
// Self-checking testbench for nucleotide_kmer_window_matcher_unit: table-driven directed beats,
// then pattern loads and samples with random content, checked against a scoreboard predictor.
// Depends on nkwm_pkg and the RTL of the unit; reads no files.
module tb_nucleotide_kmer_window_matcher_unit;
  import nkwm_pkg::*;

  localparam int PW          = 2 * PATTERN_TOKENS_DEF;
  localparam int SW          = 2 * SAMPLE_TOKENS_DEF;
  localparam int ITEMS       = 1850;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [SW-1:0]       word;
    logic [NUMBER_W-1:0] number;
  } unmatched_t;

  typedef struct {
    logic       op;
    logic [7:0] sym;
    bit         typed;
    unmatched_t want;
  } stim_row_t;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                item_valid   = 1'b0;
  logic                operation    = OP_PATTERN;
  logic [7:0]          symbol       = 8'h00;
  logic                result_stall = 1'b0;
  logic                item_stall;
  logic                result_valid;
  logic [SW-1:0]       sample_word;
  logic [NUMBER_W-1:0] sample_number;

  // Predictor state.
  logic [PW-1:0]       pat_acc     = '0;
  int                  pat_fill    = 0;
  logic [SW-1:0]       smp_acc     = '0;
  int                  smp_fill    = 0;
  logic [PW-1:0]       pat_store[PATTERN_DEPTH_DEF];
  int                  pat_stored  = 0;
  logic [NUMBER_W-1:0] smp_seq     = '0;

  unmatched_t unmatched_q[$];
  stim_row_t  stim_rows[$];
  int         errors      = 0;
  int         tokens_sent = 0;
  bit         tx_quiet    = 1'b0;
  bit         rx_quiet    = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  nucleotide_kmer_window_matcher_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .operation    (operation),
    .symbol       (symbol),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sample_word  (sample_word),
    .sample_number(sample_number)
  );

  // Returns 1 when a completed sample has no window equal to any stored pattern.
  function automatic bit screen_char(input logic op, input logic [7:0] sym,
                                     output unmatched_t res);
    logic [1:0] code;
    bit         hit;
    res = '0;
    case (sym)
      SYM_G: code = TOK_G;
      SYM_A: code = TOK_A;
      SYM_T: code = TOK_T;
      SYM_C: code = TOK_C;
      default: return 1'b0;
    endcase
    if (op == OP_PATTERN) begin
      pat_acc = {pat_acc[PW-3:0], code};
      pat_fill++;
      if (pat_fill == PATTERN_TOKENS_DEF) begin
        pat_fill = 0;
        if (pat_stored < PATTERN_DEPTH_DEF) begin
          pat_store[pat_stored] = pat_acc;
          pat_stored++;
        end
      end
      return 1'b0;
    end
    smp_acc = {smp_acc[SW-3:0], code};
    smp_fill++;
    if (smp_fill < SAMPLE_TOKENS_DEF) return 1'b0;
    smp_fill = 0;
    hit = 1'b0;
    for (int w = 0; w + PATTERN_TOKENS_DEF <= SAMPLE_TOKENS_DEF; w++)
      for (int p = 0; p < pat_stored; p++)
        if (pat_store[p] == smp_acc[2*w +: PW]) hit = 1'b1;
    res.word   = smp_acc;
    res.number = smp_seq;
    smp_seq++;
    return !hit;
  endfunction

  function automatic logic [7:0] char_of(input logic [1:0] code);
    case (code)
      TOK_G:   return SYM_G;
      TOK_A:   return SYM_A;
      TOK_T:   return SYM_T;
      default: return SYM_C;
    endcase
  endfunction

  function automatic void add_row(input logic op, input logic [7:0] sym, input bit typed,
                                  input unmatched_t want);
    stim_row_t r;
    r.op    = op;
    r.sym   = sym;
    r.typed = typed;
    r.want  = want;
    stim_rows.push_back(r);
  endfunction

  function automatic void note_mismatch(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  // Drives one beat and books its expected result once the beat is taken.
  task automatic drive_char(input logic op, input logic [7:0] sym, input bit typed,
                            input unmatched_t want);
    int         gap;
    bit         emitted;
    unmatched_t got;
    if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    operation  <= op;
    symbol     <= sym;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    tokens_sent++;
    emitted = screen_char(op, sym, got);
    if (typed) unmatched_q.push_back(want);
    else if (emitted) unmatched_q.push_back(got);
  endtask

  task automatic send_noise();
    logic [7:0] sym;
    sym = 8'($urandom_range(0, 255));
    while (sym == SYM_G || sym == SYM_A || sym == SYM_T || sym == SYM_C)
      sym = 8'($urandom_range(0, 255));
    drive_char($urandom_range(0, 1) ? OP_SAMPLE : OP_PATTERN, sym, 1'b0, '0);
  endtask

  task automatic send_token(input logic op, input logic [1:0] code);
    if ($urandom_range(0, 11) == 0) send_noise();
    drive_char(op, char_of(code), 1'b0, '0);
  endtask

  task automatic send_pattern();
    repeat (PATTERN_TOKENS_DEF) send_token(OP_PATTERN, 2'($urandom_range(0, 3)));
  endtask

  // Finishes any partial sample, then sends one whole sample, optionally built around a
  // stored pattern placed at a random window offset.
  task automatic send_sample(input bit embed);
    logic [SW-1:0] word;
    int            w;
    int            t;
    while (smp_fill != 0) send_token(OP_SAMPLE, 2'($urandom_range(0, 3)));
    word = SW'($urandom);
    if (embed && pat_stored > 0) begin
      w = $urandom_range(0, SAMPLE_TOKENS_DEF - PATTERN_TOKENS_DEF);
      word[2*w +: PW] = pat_store[$urandom_range(0, pat_stored - 1)];
      // One altered token inside the window usually turns the hit into a near miss.
      if ($urandom_range(0, 3) == 0) begin
        t = $urandom_range(w, w + PATTERN_TOKENS_DEF - 1);
        word[2*t +: 2] = word[2*t +: 2] ^ 2'($urandom_range(1, 3));
      end
    end
    for (int i = SAMPLE_TOKENS_DEF - 1; i >= 0; i--) send_token(OP_SAMPLE, word[2*i +: 2]);
  endtask

  task automatic hold_until_drained();
    item_valid <= 1'b0;
    while (unmatched_q.size() != 0) @(posedge clk);
    // A matching sample leaves nothing to wait for, so give the scan time to finish.
    repeat (PATTERN_DEPTH_DEF + 8) @(posedge clk);
  endtask

  initial begin
    add_row(OP_PATTERN, 8'h00, 1'b0, '0);
    add_row(OP_SAMPLE, 8'hFF, 1'b0, '0);
    add_row(OP_SAMPLE, 8'h67, 1'b0, '0);
    add_row(OP_PATTERN, 8'h63, 1'b0, '0);
    for (int i = 0; i < SAMPLE_TOKENS_DEF - 1; i++) begin
      add_row(OP_SAMPLE, SYM_C, 1'b0, '0);
      if (i == 6) add_row(OP_SAMPLE, 8'h80, 1'b0, '0);
    end
    // With no pattern stored yet, the all-C sample comes out whole as number zero.
    add_row(OP_SAMPLE, SYM_C, 1'b1, {{SW{1'b1}}, {NUMBER_W{1'b0}}});
    add_row(OP_PATTERN, SYM_G, 1'b0, '0);
    add_row(OP_PATTERN, SYM_A, 1'b0, '0);
    add_row(OP_PATTERN, SYM_T, 1'b0, '0);
    add_row(OP_PATTERN, SYM_C, 1'b0, '0);
    add_row(OP_PATTERN, SYM_G, 1'b0, '0);
    add_row(OP_PATTERN, SYM_A, 1'b0, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i])
      drive_char(stim_rows[i].op, stim_rows[i].sym, stim_rows[i].typed, stim_rows[i].want);

    // Samples against an empty or nearly empty table.
    for (int s = 0; s < 12; s++) begin
      if (s == 4) repeat (3) send_pattern();
      send_sample(s > 4);
    end
    hold_until_drained();

    // Fill the table past its depth, with samples mixed in along the way.
    for (int n = 0; n < PATTERN_DEPTH_DEF + 6; n++) begin
      send_pattern();
      if (n % 7 == 6) send_sample(1'b1);
    end

    while (tokens_sent < ITEMS) begin
      if ($urandom_range(0, 9) == 0) send_pattern();
      else send_sample($urandom_range(0, 1) != 0);
    end

    hold_until_drained();
    if (errors == 0) $display("PASS nucleotide_kmer_window_matcher_unit");
    else $display("FAIL nucleotide_kmer_window_matcher_unit");
    $finish;
  end

  initial begin : result_sink
    int hold;
    forever begin
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
      hold = rx_quiet ? 0 : $urandom_range(0, 13);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    unmatched_t want;
    if (!rst && result_valid && !result_stall) begin
      if (unmatched_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result: word %h number %0d",
                                sample_word, sample_number));
      end else begin
        want = unmatched_q.pop_front();
        if (sample_word !== want.word)
          note_mismatch($sformatf("sample_word: expected %h, got %h (sample %0d)",
                                  want.word, sample_word, want.number));
        if (sample_number !== want.number)
          note_mismatch($sformatf("sample_number: expected %0d, got %0d",
                                  want.number, sample_number));
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) idle = 0;
      else idle++;
    end
    $display("FAIL nucleotide_kmer_window_matcher_unit");
    $finish;
  end

endmodule
